@@ hdl/ktis_pkg.sv @@
// ktis_pkg: constants, entry and handshake types for the keyed table block
// used by ktis_ctrl, ktis_dp and keyed_table_insert_remove_search
// no dependencies
`timescale 1ns / 1ps

package ktis_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_BYTES = 8;
	localparam int MAX_OUT   = 16;

	localparam int KEY_W    = 64;
	localparam int AMT_W    = 16;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;
	localparam int FILL_W   = 5;

	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);
	localparam int CMP_W     = ((CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W) + 1;

	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] name;
		logic [KEY_W-1:0] kind;
		logic [AMT_W-1:0] amount;
	} entry_t;

	typedef enum logic [1:0] {
		RD_NONE  = 2'd0,
		RD_CUR   = 2'd1,
		RD_NEXT  = 2'd2,
		RD_NEXT2 = 2'd3
	} rd_cmd_t;

	typedef enum logic [1:0] {
		WR_NONE   = 2'd0,
		WR_INSERT = 2'd1,
		WR_SHIFT  = 2'd2
	} wr_cmd_t;

	typedef enum logic [2:0] {
		RES_NONE    = 3'd0,
		RES_FULL    = 3'd1,
		RES_EMPTY   = 3'd2,
		RES_MISSING = 3'd3,
		RES_INSERT  = 3'd4,
		RES_FOUND   = 3'd5
	} res_cmd_t;

	typedef enum logic [1:0] {
		EMIT_NONE = 2'd0,
		EMIT_RES  = 2'd1,
		EMIT_LIST = 2'd2
	} emit_cmd_t;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_CHECK    = 6'b000100,
		S_SHIFT    = 6'b001000,
		S_EMIT     = 6'b010000,
		S_LIST     = 6'b100000
	} state_t;

	typedef struct packed {
		logic      load_in;
		logic      idx_inc;
		logic      cnt_dec;
		rd_cmd_t   rd;
		wr_cmd_t   wr;
		res_cmd_t  res;
		emit_cmd_t emit;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic match;
		logic idx_last;
		logic shift_more;
		logic list_last;
		logic out_free;
	} dp_sts_t;

endpackage

@@ hdl/ktis_dp.sv @@
// ktis_dp: entry memory, count, scan index, result and output registers
// depends on ktis_pkg
`timescale 1ns / 1ps

module ktis_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ktis_pkg::dp_cmd_t              cmd,
	output ktis_pkg::dp_sts_t              sts,
	input  logic [ktis_pkg::OP_W-1:0]      opcode,
	input  logic [ktis_pkg::KEY_W-1:0]     key_name,
	input  logic [ktis_pkg::KEY_W-1:0]     kind_tag,
	input  logic [ktis_pkg::AMT_W-1:0]     amount,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ktis_pkg::STATUS_W-1:0]  status,
	output logic [ktis_pkg::SLOT_W-1:0]    slot,
	output logic [ktis_pkg::KEY_W-1:0]     out_name,
	output logic [ktis_pkg::KEY_W-1:0]     out_kind,
	output logic [ktis_pkg::AMT_W-1:0]     out_amount,
	output logic [ktis_pkg::FILL_W-1:0]    fill_count,
	output logic                           last
);

	localparam int IDX_W = ktis_pkg::IDX_W;
	localparam int CNT_W = ktis_pkg::CNT_W;
	localparam int CMP_W = ktis_pkg::CMP_W;

	ktis_pkg::entry_t mem [ktis_pkg::CAPACITY];
	ktis_pkg::entry_t rd_data_q;
	ktis_pkg::entry_t in_entry_q;
	ktis_pkg::entry_t res_entry_q;
	ktis_pkg::op_t    op_q;
	ktis_pkg::status_t res_status_q;
	logic [IDX_W-1:0] res_slot_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;

	ktis_pkg::status_t                 status_q;
	logic [ktis_pkg::SLOT_W-1:0]       slot_q;
	ktis_pkg::entry_t                  out_entry_q;
	logic [ktis_pkg::FILL_W-1:0]       fill_q;
	logic                              last_q;

	logic [IDX_W:0]   rd_sum;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             rd_en;
	logic             wr_en;
	logic [CMP_W-1:0] idx_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] list_n;
	logic             out_free;

	// read address relative to the scan index
	always_comb begin
		rd_en  = 1'b1;
		rd_sum = {1'b0, idx_q};
		case (cmd.rd)
			ktis_pkg::RD_NONE:  rd_en  = 1'b0;
			ktis_pkg::RD_CUR:   rd_sum = {1'b0, idx_q};
			ktis_pkg::RD_NEXT:  rd_sum = {1'b0, idx_q} + (IDX_W+1)'(1);
			ktis_pkg::RD_NEXT2: rd_sum = {1'b0, idx_q} + (IDX_W+1)'(2);
			default:            rd_en  = 1'b0;
		endcase
		rd_addr = rd_sum[IDX_W-1:0];
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = idx_q;
		case (cmd.wr)
			ktis_pkg::WR_NONE:   wr_en   = 1'b0;
			ktis_pkg::WR_INSERT: wr_addr = count_q[IDX_W-1:0];
			ktis_pkg::WR_SHIFT:  wr_addr = idx_q;
			default:             wr_en   = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (cmd.wr == ktis_pkg::WR_INSERT) begin
				mem[wr_addr] <= in_entry_q;
			end else begin
				mem[wr_addr] <= rd_data_q;
			end
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// status toward the controller
	assign idx_w    = CMP_W'(idx_q);
	assign cnt_w    = CMP_W'(count_q);
	assign list_n   = (cnt_w > CMP_W'(ktis_pkg::MAX_OUT)) ? CMP_W'(ktis_pkg::MAX_OUT) : cnt_w;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.empty      = (count_q == '0);
		sts.full       = (count_q == CNT_W'(ktis_pkg::CAPACITY));
		sts.match      = (rd_data_q.name == in_entry_q.name);
		sts.idx_last   = ((idx_w + CMP_W'(1)) == cnt_w);
		sts.shift_more = ((idx_w + CMP_W'(2)) < cnt_w);
		sts.list_last  = ((idx_w + CMP_W'(1)) == list_n);
		sts.out_free   = out_free;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.wr == ktis_pkg::WR_INSERT) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.emit != ktis_pkg::EMIT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q              <= ktis_pkg::op_t'(opcode);
			in_entry_q.name   <= key_name & ktis_pkg::KEY_MASK;
			in_entry_q.kind   <= kind_tag & ktis_pkg::KEY_MASK;
			in_entry_q.amount <= amount;
		end
		case (cmd.res)
			ktis_pkg::RES_NONE: begin
			end
			ktis_pkg::RES_FULL: begin
				res_status_q <= ktis_pkg::ST_FULL;
				res_slot_q   <= '0;
				res_entry_q  <= '0;
			end
			ktis_pkg::RES_EMPTY: begin
				res_status_q <= ktis_pkg::ST_EMPTY;
				res_slot_q   <= '0;
				res_entry_q  <= '0;
			end
			ktis_pkg::RES_MISSING: begin
				res_status_q <= ktis_pkg::ST_MISSING;
				res_slot_q   <= '0;
				res_entry_q  <= '0;
			end
			ktis_pkg::RES_INSERT: begin
				res_status_q <= ktis_pkg::ST_OK;
				res_slot_q   <= count_q[IDX_W-1:0];
				res_entry_q  <= in_entry_q;
			end
			ktis_pkg::RES_FOUND: begin
				res_status_q <= ktis_pkg::ST_OK;
				res_slot_q   <= idx_q;
				res_entry_q  <= rd_data_q;
			end
			default: begin
			end
		endcase
		case (cmd.emit)
			ktis_pkg::EMIT_NONE: begin
			end
			ktis_pkg::EMIT_RES: begin
				status_q    <= res_status_q;
				slot_q      <= ktis_pkg::SLOT_W'(res_slot_q);
				out_entry_q <= res_entry_q;
				fill_q      <= ktis_pkg::FILL_W'(count_q);
				last_q      <= 1'b1;
			end
			ktis_pkg::EMIT_LIST: begin
				status_q    <= ktis_pkg::ST_OK;
				slot_q      <= ktis_pkg::SLOT_W'(idx_q);
				out_entry_q <= rd_data_q;
				fill_q      <= ktis_pkg::FILL_W'(count_q);
				last_q      <= sts.list_last;
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign out_name   = out_entry_q.name;
	assign out_kind   = out_entry_q.kind;
	assign out_amount = out_entry_q.amount;
	assign fill_count = fill_q;
	assign last       = last_q;

endmodule

@@ hdl/ktis_ctrl.sv @@
// ktis_ctrl: sequencer for insert, remove, search and list operations
// depends on ktis_pkg
`timescale 1ns / 1ps

module ktis_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ktis_pkg::dp_sts_t  sts,
	output ktis_pkg::dp_cmd_t  cmd
);

	ktis_pkg::state_t state_q;
	ktis_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ktis_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign in_stall = (state_q != ktis_pkg::S_IDLE);

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ktis_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_next  = ktis_pkg::S_DISPATCH;
				end
			end
			ktis_pkg::S_DISPATCH: begin
				if (sts.op == ktis_pkg::OP_INSERT) begin
					if (sts.full) begin
						cmd.res = ktis_pkg::RES_FULL;
					end else begin
						cmd.wr  = ktis_pkg::WR_INSERT;
						cmd.res = ktis_pkg::RES_INSERT;
					end
					state_next = ktis_pkg::S_EMIT;
				end else if (sts.empty) begin
					cmd.res    = ktis_pkg::RES_EMPTY;
					state_next = ktis_pkg::S_EMIT;
				end else begin
					cmd.rd = ktis_pkg::RD_CUR;
					if (sts.op == ktis_pkg::OP_LIST) begin
						state_next = ktis_pkg::S_LIST;
					end else begin
						state_next = ktis_pkg::S_CHECK;
					end
				end
			end
			ktis_pkg::S_CHECK: begin
				if (sts.match) begin
					cmd.res = ktis_pkg::RES_FOUND;
					if (sts.op == ktis_pkg::OP_REMOVE && !sts.idx_last) begin
						cmd.rd     = ktis_pkg::RD_NEXT;
						state_next = ktis_pkg::S_SHIFT;
					end else begin
						cmd.cnt_dec = (sts.op == ktis_pkg::OP_REMOVE);
						state_next  = ktis_pkg::S_EMIT;
					end
				end else if (sts.idx_last) begin
					cmd.res    = ktis_pkg::RES_MISSING;
					state_next = ktis_pkg::S_EMIT;
				end else begin
					cmd.rd      = ktis_pkg::RD_NEXT;
					cmd.idx_inc = 1'b1;
				end
			end
			ktis_pkg::S_SHIFT: begin
				// move the entry above the index down, fetch the one after it
				cmd.wr      = ktis_pkg::WR_SHIFT;
				cmd.idx_inc = 1'b1;
				if (sts.shift_more) begin
					cmd.rd = ktis_pkg::RD_NEXT2;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_next  = ktis_pkg::S_EMIT;
				end
			end
			ktis_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit   = ktis_pkg::EMIT_RES;
					state_next = ktis_pkg::S_IDLE;
				end
			end
			ktis_pkg::S_LIST: begin
				if (sts.out_free) begin
					cmd.emit = ktis_pkg::EMIT_LIST;
					if (sts.list_last) begin
						state_next = ktis_pkg::S_IDLE;
					end else begin
						cmd.rd      = ktis_pkg::RD_NEXT;
						cmd.idx_inc = 1'b1;
					end
				end
			end
			default: begin
				state_next = ktis_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/keyed_table_insert_remove_search.sv @@
// keyed_table_insert_remove_search: top level of the keyed table block
// instantiates ktis_ctrl and ktis_dp, depends on ktis_pkg
//
// usage: one input item on the in channel (opcode, key_name, kind_tag, amount)
// is taken when in_valid is high and in_stall is low; results leave on the
// out channel when out_valid is high and out_stall is low, the final result
// of an item carries last.
// insert and empty or full errors go from accept through dispatch and emit to
// out_valid; search and remove scan one entry per cycle from entry 0, and
// remove then moves each later entry down one per cycle before its result is
// shown. list emits one entry per cycle from the memory read port while the
// receiver does not stall, starting from entry 0 after accept and dispatch.
// one item is worked on at a time, in_stall is high from accept until the
// last result of the item is loaded into the output register.
// the worst case is a remove or a missed search on a full table; scan and
// shift together visit each entry once, plus accept, dispatch and emit.
// reset clears the entry count, scan index and output valid flag, the table
// is empty; entries themselves are not cleared. a stalled receiver holds the
// result register and the emit or list state, no result is dropped.
`timescale 1ns / 1ps

module keyed_table_insert_remove_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ktis_pkg::OP_W-1:0]      opcode,
	input  logic [ktis_pkg::KEY_W-1:0]     key_name,
	input  logic [ktis_pkg::KEY_W-1:0]     kind_tag,
	input  logic [ktis_pkg::AMT_W-1:0]     amount,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ktis_pkg::STATUS_W-1:0]  status,
	output logic [ktis_pkg::SLOT_W-1:0]    slot,
	output logic [ktis_pkg::KEY_W-1:0]     out_name,
	output logic [ktis_pkg::KEY_W-1:0]     out_kind,
	output logic [ktis_pkg::AMT_W-1:0]     out_amount,
	output logic [ktis_pkg::FILL_W-1:0]    fill_count,
	output logic                           last
);

	ktis_pkg::dp_cmd_t cmd;
	ktis_pkg::dp_sts_t sts;

	ktis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ktis_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.key_name   (key_name),
		.kind_tag   (kind_tag),
		.amount     (amount),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.slot       (slot),
		.out_name   (out_name),
		.out_kind   (out_kind),
		.out_amount (out_amount),
		.fill_count (fill_count),
		.last       (last)
	);

endmodule
